[rtl/sbst_pkg.sv]
package sbst_pkg;

   // field widths
   localparam int COORD_WIDTH = 24;
   localparam int AXES        = 3;
   localparam int DIFF_W      = COORD_WIDTH + 2;
   localparam int DEN_W       = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int LEN_W       = COORD_WIDTH + 1;
   localparam int DIST_W      = COORD_WIDTH + 1;
   localparam int NUM_W       = LEN_W + DEN_W;
   localparam int SUM_W       = 2 * DEN_W + 2;
   localparam int DIV_N       = NUM_W - DEN_W;
   localparam int CSR_IDX_W   = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_END_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END_Z   = 3'd5;

   // one axis: clamped entry and exit fractions, and the slab test
   typedef struct packed {
      logic signed [DIFF_W-1:0] en_n;
      logic [DEN_W-1:0]         en_d;
      logic signed [DIFF_W-1:0] ex_n;
      logic [DEN_W-1:0]         ex_d;
      logic                     ok;
   } lane_type;

   // merge result handed to the divider
   typedef struct packed {
      logic             hit;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } merge_type;

   // signed numerator times positive denominator
   function automatic logic signed [PROD_W-1:0] mul_s(input logic signed [DIFF_W-1:0] n,
                                                      input logic [DEN_W-1:0] d);
      logic signed [PROD_W-1:0] nx;
      logic signed [PROD_W-1:0] dx;
      nx = PROD_W'(n);
      dx = $signed(PROD_W'(d));
      return nx * dx;
   endfunction

endpackage

[rtl/sbst_lane.sv]
module sbst_lane (
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] s,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] e,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] lo,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] hi,
   output sbst_pkg::lane_type                      res
);
   import sbst_pkg::*;

   logic signed [DIFF_W-1:0] d, na, nb, ma, mb, near, far;
   logic [DEN_W-1:0]         den;
   logic                     neg, zero, in_slab;

   // direction and offsets, flipped onto a positive direction
   always_comb begin
      d       = DIFF_W'(e) - DIFF_W'(s);
      na      = DIFF_W'(lo) - DIFF_W'(s);
      nb      = DIFF_W'(hi) - DIFF_W'(s);
      neg     = d < 0;
      zero    = d == 0;
      den     = neg ? DEN_W'(-d) : DEN_W'(d);
      ma      = neg ? -na : na;
      mb      = neg ? -nb : nb;
      near    = (ma < mb) ? ma : mb;
      far     = (ma < mb) ? mb : ma;
      in_slab = (s >= lo) && (s <= hi);
   end

   // clamp entry to zero and exit to one
   always_comb begin
      if (zero || near < 0) begin
         res.en_n = '0;
         res.en_d = DEN_W'(1);
      end else begin
         res.en_n = near;
         res.en_d = den;
      end
      if (zero || far >= $signed({1'b0, den})) begin
         res.ex_n = DIFF_W'(1);
         res.ex_d = DEN_W'(1);
      end else begin
         res.ex_n = far;
         res.ex_d = den;
      end
      res.ok = zero ? in_slab : 1'b1;
   end

endmodule

[rtl/sbst_merge.sv]
module sbst_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic                        in_box,
   input  sbst_pkg::lane_type          lane [sbst_pkg::AXES],
   input  logic [sbst_pkg::LEN_W-1:0]  len,
   output logic                        out_valid,
   output sbst_pkg::merge_type         out_data
);
   import sbst_pkg::*;

   logic     v_ff [4];
   lane_type a_ff [AXES];
   logic     a_box_ff;

   lane_type b_ff [AXES];
   logic     b_ok_ff, b_box_ff;
   logic signed [PROD_W-1:0] b_e1_ff, b_e2_ff, b_x1_ff, b_x2_ff;

   lane_type c_sel_ff, c_z_ff;
   logic     c_ok_ff, c_box_ff;
   logic signed [PROD_W-1:0] c_e1_ff, c_e2_ff, c_x1_ff, c_x2_ff;

   logic signed [DIFF_W-1:0] d_en_n_ff;
   logic [DEN_W-1:0]         d_en_d_ff;
   logic                     d_ok_ff, d_box_ff;
   logic signed [PROD_W-1:0] d_pe_ff, d_px_ff;

   lane_type b_sel, c_fin;

   // pick larger entry and smaller exit of x and y
   always_comb begin
      b_sel = b_ff[0];
      if (b_e1_ff < b_e2_ff) begin
         b_sel.en_n = b_ff[1].en_n;
         b_sel.en_d = b_ff[1].en_d;
      end
      if (b_x1_ff > b_x2_ff) begin
         b_sel.ex_n = b_ff[1].ex_n;
         b_sel.ex_d = b_ff[1].ex_d;
      end
   end

   // then against z
   always_comb begin
      c_fin = c_sel_ff;
      if (c_e1_ff < c_e2_ff) begin
         c_fin.en_n = c_z_ff.en_n;
         c_fin.en_d = c_z_ff.en_d;
      end
      if (c_x1_ff > c_x2_ff) begin
         c_fin.ex_n = c_z_ff.ex_n;
         c_fin.ex_d = c_z_ff.ex_d;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) v_ff[k] <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < 4; k++) v_ff[k] <= v_ff[k-1];
         out_valid <= v_ff[3];
      end
   end

   // cross products and selections
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= lane;
         a_box_ff <= in_box;

         b_ff     <= a_ff;
         b_ok_ff  <= a_ff[0].ok & a_ff[1].ok & a_ff[2].ok;
         b_box_ff <= a_box_ff;
         b_e1_ff  <= mul_s(a_ff[0].en_n, a_ff[1].en_d);
         b_e2_ff  <= mul_s(a_ff[1].en_n, a_ff[0].en_d);
         b_x1_ff  <= mul_s(a_ff[0].ex_n, a_ff[1].ex_d);
         b_x2_ff  <= mul_s(a_ff[1].ex_n, a_ff[0].ex_d);

         c_sel_ff <= b_sel;
         c_z_ff   <= b_ff[2];
         c_ok_ff  <= b_ok_ff;
         c_box_ff <= b_box_ff;
         c_e1_ff  <= mul_s(b_sel.en_n, b_ff[2].en_d);
         c_e2_ff  <= mul_s(b_ff[2].en_n, b_sel.en_d);
         c_x1_ff  <= mul_s(b_sel.ex_n, b_ff[2].ex_d);
         c_x2_ff  <= mul_s(b_ff[2].ex_n, b_sel.ex_d);

         d_en_n_ff <= c_fin.en_n;
         d_en_d_ff <= c_fin.en_d;
         d_ok_ff   <= c_ok_ff;
         d_box_ff  <= c_box_ff;
         d_pe_ff   <= mul_s(c_fin.en_n, c_fin.ex_d);
         d_px_ff   <= mul_s(c_fin.ex_n, c_fin.en_d);

         // hit when entry does not pass exit; numerator of the distance
         out_data.hit <= d_box_ff & d_ok_ff & (d_pe_ff <= d_px_ff);
         out_data.num <= NUM_W'(len) * NUM_W'(DEN_W'(d_en_n_ff));
         out_data.den <= d_en_d_ff;
      end
   end

endmodule

[rtl/sbst_div.sv]
module sbst_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  sbst_pkg::merge_type         in_data,
   output logic                        out_valid,
   output logic                        out_hit,
   output logic [sbst_pkg::DIST_W-1:0] out_quot
);
   import sbst_pkg::*;

   logic             v_ff   [DIV_N];
   logic             hit_ff [DIV_N];
   logic [DEN_W-1:0] den_ff [DIV_N];
   logic [DEN_W-1:0] rem_ff [DIV_N];
   logic [DIV_N-1:0] low_ff [DIV_N];
   logic [DIV_N-1:0] q_ff   [DIV_N];
   logic [DEN_W-1:0] rem_in [DIV_N];
   logic [DIV_N-1:0] low_in [DIV_N];
   logic [DIV_N-1:0] q_in   [DIV_N];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [DEN_W-1:0] src_rem;
      logic [DIV_N-1:0] src_low;
      logic [DIV_N-1:0] src_q;
      logic [DEN_W-1:0] src_den;
      logic [DEN_W:0]   t;
      logic             ge;
      for (int k = 0; k < DIV_N; k++) begin
         if (k == 0) begin
            src_rem = in_data.num[NUM_W-1:DIV_N];
            src_low = in_data.num[DIV_N-1:0];
            src_q   = '0;
            src_den = in_data.den;
         end else begin
            src_rem = rem_ff[k-1];
            src_low = low_ff[k-1];
            src_q   = q_ff[k-1];
            src_den = den_ff[k-1];
         end
         t         = {src_rem, src_low[DIV_N-1]};
         ge        = t >= {1'b0, src_den};
         rem_in[k] = ge ? DEN_W'(t - {1'b0, src_den}) : DEN_W'(t);
         low_in[k] = src_low << 1;
         q_in[k]   = {src_q[DIV_N-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_N; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < DIV_N; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff[0] <= in_data.hit;
         den_ff[0] <= in_data.den;
         for (int k = 1; k < DIV_N; k++) begin
            hit_ff[k] <= hit_ff[k-1];
            den_ff[k] <= den_ff[k-1];
         end
         for (int k = 0; k < DIV_N; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign out_valid = v_ff[DIV_N-1];
   assign out_hit   = hit_ff[DIV_N-1];
   assign out_quot  = DIST_W'(q_ff[DIV_N-1]);

endmodule

[rtl/sbst_sqrt.sv]
module sbst_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sbst_pkg::DEN_W-1:0]  dmag [sbst_pkg::AXES],
   output logic                        busy,
   output logic [sbst_pkg::LEN_W-1:0]  len
);
   import sbst_pkg::*;

   localparam int CNT_W = $clog2(LEN_W);

   typedef enum logic [1:0] {S_IDLE, S_SQUARE, S_ROOT} state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [LEN_W-1:0]   root_ff;
   logic [LEN_W-1:0]   trial;
   logic [DEN_W-1:0]   mul_op;
   logic [2*DEN_W-1:0] prod;

   // one shared multiplier: squares first, then trial roots
   always_comb begin
      trial  = root_ff | (LEN_W'(1) << cnt_ff);
      mul_op = (state_ff == S_ROOT) ? DEN_W'(trial) : dmag[cnt_ff[1:0]];
      prod   = (2*DEN_W)'(mul_op) * (2*DEN_W)'(mul_op);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         root_ff  <= '0;
      end else if (start) begin
         state_ff <= S_SQUARE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
            end
            S_SQUARE: begin
               sum_ff <= sum_ff + SUM_W'(prod);
               if (cnt_ff == CNT_W'(AXES - 1)) begin
                  state_ff <= S_ROOT;
                  cnt_ff   <= CNT_W'(LEN_W - 1);
                  root_ff  <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ROOT: begin
               if (SUM_W'(prod) <= sum_ff) root_ff <= trial;
               if (cnt_ff == '0) state_ff <= S_IDLE;
               else cnt_ff <= cnt_ff - 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = state_ff != S_IDLE;
   assign len  = root_ff;

endmodule

[rtl/segment_box_slab_test_core.sv]
// channel  direction  beat carries
// csr      in         csr_index, csr_data (segment start and end)
// req      in         box corners and req_box_valid
// rsp      out        rsp_hit, rsp_entry_distance
//
// one box a cycle while req_ready is high; the path from req beat to rsp beat runs through
// four merge stages, one product stage, 25 divider stages and an output register
// after each csr beat the segment length is rebuilt in the
// square-root unit; req_ready stays low meanwhile
// reset clears the registers to a zero segment; a skid stage keeps one
// more box moving while a result waits on rsp_ready
module segment_box_slab_test_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sbst_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] csr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [sbst_pkg::COORD_WIDTH-1:0] req_box_max_z,
   input  logic                                   req_box_valid,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic [sbst_pkg::DIST_W-1:0]            rsp_entry_distance
);
   import sbst_pkg::*;

   logic signed [COORD_WIDTH-1:0] start_ff [AXES];
   logic signed [COORD_WIDTH-1:0] end_ff   [AXES];
   logic signed [COORD_WIDTH-1:0] lo_arr   [AXES];
   logic signed [COORD_WIDTH-1:0] hi_arr   [AXES];
   logic [DEN_W-1:0]              dmag     [AXES];
   lane_type                      lane_res [AXES];

   logic              csr_fire, en, accept, busy;
   logic [LEN_W-1:0]  len;
   logic              m_valid;
   merge_type         m_data;
   logic              p_valid, p_hit;
   logic [DIST_W-1:0] p_quot;
   logic              skid_valid_ff, skid_hit_ff;
   logic [DIST_W-1:0] skid_dist_ff;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign en        = ~skid_valid_ff;
   assign req_ready = en & ~busy;
   assign accept    = req_valid & req_ready;

   // segment registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            start_ff[a] <= '0;
            end_ff[a]   <= '0;
         end
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_START_X: start_ff[0] <= csr_data;
            REG_START_Y: start_ff[1] <= csr_data;
            REG_START_Z: start_ff[2] <= csr_data;
            REG_END_X:   end_ff[0]   <= csr_data;
            REG_END_Y:   end_ff[1]   <= csr_data;
            REG_END_Z:   end_ff[2]   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // direction magnitudes for the length
   always_comb begin
      logic signed [DIFF_W-1:0] d;
      for (int a = 0; a < AXES; a++) begin
         d       = DIFF_W'(end_ff[a]) - DIFF_W'(start_ff[a]);
         dmag[a] = (d < 0) ? DEN_W'(-d) : DEN_W'(d);
      end
   end

   assign lo_arr[0] = req_box_min_x;
   assign lo_arr[1] = req_box_min_y;
   assign lo_arr[2] = req_box_min_z;
   assign hi_arr[0] = req_box_max_x;
   assign hi_arr[1] = req_box_max_y;
   assign hi_arr[2] = req_box_max_z;

   sbst_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (csr_fire),
      .dmag  (dmag),
      .busy  (busy),
      .len   (len)
   );

   // one lane per axis
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      sbst_lane u_lane (
         .s   (start_ff[a]),
         .e   (end_ff[a]),
         .lo  (lo_arr[a]),
         .hi  (hi_arr[a]),
         .res (lane_res[a])
      );
   end

   sbst_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .in_box    (req_box_valid),
      .lane      (lane_res),
      .len       (len),
      .out_valid (m_valid),
      .out_data  (m_data)
   );

   sbst_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid),
      .in_data   (m_data),
      .out_valid (p_valid),
      .out_hit   (p_hit),
      .out_quot  (p_quot)
   );

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid     <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (~rsp_valid | rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid     <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid <= p_valid;
         end
      end else if (p_valid & en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (~rsp_valid | rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_hit            <= skid_hit_ff;
            rsp_entry_distance <= skid_dist_ff;
         end else begin
            rsp_hit            <= p_hit;
            rsp_entry_distance <= p_hit ? p_quot : '0;
         end
      end else if (p_valid & en) begin
         skid_hit_ff  <= p_hit;
         skid_dist_ff <= p_hit ? p_quot : '0;
      end
   end

endmodule
